FILE: rtl/ftss_pkg.sv
// shared types and constants for the four-timestamp sync stamper
package ftss_pkg;

	localparam int RING_DEPTH_DEF = 8;

	// configuration port
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_REMOTE_WAIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WIRE_RTT    = 1'b1;
	localparam logic [CFG_W-1:0] MAX_REMOTE_WAIT_RST = 32'd100000;
	localparam logic [CFG_W-1:0] MAX_WIRE_RTT_RST    = 32'd10000;

	// item modes
	localparam logic MODE_SYNC  = 1'b0;
	localparam logic MODE_FRAME = 1'b1;

	// arithmetic constants
	localparam logic [12:0] WEIGHT_Q16 = 13'd6554;
	localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;
	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic        mode;
		logic [63:0] now_us;
		logic [63:0] remote_sync_rx_us;
		logic [63:0] remote_capture_us;
		logic [15:0] frame_seq;
		logic [31:0] remote_latency_us;
	} in_item_t;

	typedef struct packed {
		logic [63:0]        stamp_us;
		logic [31:0]        end_to_end_latency_us;
		logic [15:0]        gap_count;
		logic [31:0]        loss_total;
		logic               offset_valid;
		logic               sample_taken;
		logic signed [63:0] offset_q8;
	} out_item_t;

	// acceptance window for a stored send time: lo < t1 < hi
	typedef struct packed {
		logic signed [65:0] lo;
		logic signed [65:0] hi;
	} scan_win_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic        go;
		logic        found;
		logic [63:0] best;
	} scan_tok_t;

endpackage

FILE: rtl/four_timestamp_clock_sync_stamper_core.sv
// top level of the four-timestamp clock sync stamper
//
// usage:
//  - input channel (in_valid / in_stall / in_data): a mode 0 item records a
//    sync send time in the ring and gives no result; a mode 1 item is a
//    received frame and gives exactly one result on the output channel
//  - output channel (out_valid / out_stall / out_data): one result register
//  - config port (cfg_we / cfg_idx / cfg_data): write only, takes effect at
//    the next edge; write it only while no frame is in flight
//  - a mode 0 item is written into the ring as it is taken; the block takes the next item at once
//  - a frame steps through wait, hi, lo, launch and the ring scan; with a
//    sample found it goes on through sum, diff, raw and sdif, and once
//    samples are smoothed also through mul, acc and upd; every frame ends
//    with off, cand, clamp and final; the ring walk goes one cell per cycle
//  - in_stall is high while a frame is worked on
//  - if the receiver stalls, a finished result waits in the output register;
//    a following frame completes up to its last step and then waits there
//  - reset clears the ring, counters, offset and the output valid, and loads
//    the register defaults; no clearing pass is needed
module four_timestamp_clock_sync_stamper_core #(
	parameter int RING_DEPTH = ftss_pkg::RING_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  ftss_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output ftss_pkg::out_item_t                out_data,
	input  logic                               cfg_we,
	input  logic [ftss_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [ftss_pkg::CFG_W-1:0]         cfg_data
);
	import ftss_pkg::*;

	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic signed [65:0] Q8_HI = 66'sd72057594037927935;
	localparam logic signed [65:0] Q8_LO = -66'sd72057594037927936;

	typedef enum logic [16:0] {
		ST_IDLE   = 17'h00001,
		ST_WAIT   = 17'h00002,
		ST_HI     = 17'h00004,
		ST_LO     = 17'h00008,
		ST_LAUNCH = 17'h00010,
		ST_SCAN   = 17'h00020,
		ST_SUM    = 17'h00040,
		ST_DIFF   = 17'h00080,
		ST_RAW    = 17'h00100,
		ST_SDIF   = 17'h00200,
		ST_MUL    = 17'h00400,
		ST_ACC    = 17'h00800,
		ST_UPD    = 17'h01000,
		ST_OFF    = 17'h02000,
		ST_CAND   = 17'h04000,
		ST_CLAMP  = 17'h08000,
		ST_FINAL  = 17'h10000
	} state_t;

	state_t state_q, state_d;

	// configuration registers
	logic [CFG_W-1:0] max_wait_q;
	logic [CFG_W-1:0] max_rtt_q;

	// block state
	logic [PTR_W-1:0]   wr_pos_q;
	logic [15:0]        prev_seq_q;
	logic               await_q;
	logic               ready_q;
	logic signed [63:0] smooth_q;
	logic [63:0]        last_q;
	logic [31:0]        missed_q;

	// frame working registers
	in_item_t           item_q;
	logic [15:0]        gap_q;
	logic               chk_q;
	logic [63:0]        wait_q;
	logic [64:0]        s2_q;
	logic               wok_q;
	logic signed [65:0] hi_q;
	logic signed [65:0] lo_q;
	logic               sample_q;
	logic [63:0]        best_q;
	logic [64:0]        s1_q;
	logic signed [65:0] diff_q;
	logic signed [63:0] raw_q;
	logic signed [63:0] sdiff_q;
	logic [44:0]        plo_q;
	logic signed [45:0] phi_q;
	logic signed [63:0] inc_q;
	logic signed [63:0] off_q;
	logic signed [65:0] cand_q;
	logic signed [65:0] nt_q;
	logic signed [65:0] v_q;
	logic [63:0]        stc_q;

	// output register
	logic      out_valid_q;
	out_item_t out_q;

	// handshake
	logic in_acc;
	logic out_take;
	logic load_ok;
	logic ring_we;

	// combinational datapath
	logic [15:0]        gap_c;
	logic [64:0]        wd_c;
	logic               scan_hit;
	logic signed [63:0] raw_c;
	logic signed [64:0] sd65_c;
	logic signed [63:0] sdiff_c;
	logic [44:0]        plo_c;
	logic signed [45:0] phi_c;
	logic signed [77:0] acc_c;
	logic signed [65:0] off_x;
	logic signed [63:0] off_c;
	logic [63:0]        stc_c;
	logic [32:0]        lat_sum;
	logic [31:0]        lat_c;
	logic [63:0]        base_c;
	logic [63:0]        stamp_c;
	logic               v_pos;

	scan_win_t win;
	scan_tok_t tok [RING_DEPTH+1];

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign load_ok   = !out_valid_q || !out_stall;
	assign ring_we   = in_acc && (in_data.mode == MODE_SYNC);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ring of cells; the token enters cell 0 once per frame
	assign win.lo       = lo_q;
	assign win.hi       = hi_q;
	assign tok[0].go    = (state_q == ST_LAUNCH);
	assign tok[0].found = 1'b0;
	assign tok[0].best  = '0;

	for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
		ftss_ring_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (ring_we && (wr_pos_q == PTR_W'(i))),
			.wr_data (in_data.now_us),
			.win     (win),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	assign scan_hit = wok_q && tok[RING_DEPTH].found;

	// sequence gap and remote hold time
	assign gap_c = item_q.frame_seq - (prev_seq_q + 16'd1);
	assign wd_c  = {1'b0, item_q.remote_capture_us} - {1'b0, item_q.remote_sync_rx_us};

	// raw offset in q8: half difference times 256, saturated
	always_comb begin
		if (diff_q > Q8_HI) begin
			raw_c = S64_MAX;
		end else if (diff_q < Q8_LO) begin
			raw_c = S64_MIN;
		end else begin
			raw_c = {diff_q[56:0], 7'b0};
		end
	end

	// saturated raw minus smoothed
	assign sd65_c  = {raw_q[63], raw_q} - {smooth_q[63], smooth_q};
	assign sdiff_c = (sd65_c[64] != sd65_c[63]) ? (sd65_c[64] ? S64_MIN : S64_MAX)
	                                            : sd65_c[63:0];

	// weight 0.1 in q0.16, split into two 32-bit partial products
	assign plo_c = 45'(sdiff_q[31:0]) * 45'(WEIGHT_Q16);
	assign phi_c = 46'($signed(sdiff_q[63:32])) * 46'($signed({1'b0, WEIGHT_Q16}));
	assign acc_c = $signed({phi_q, 32'b0}) + $signed({33'b0, plo_q}) + $signed(78'd32768);

	// offset in whole microseconds, truncated toward zero
	assign off_c = (smooth_q + (smooth_q[63] ? 64'sd255 : 64'sd0)) >>> 8;
	assign off_x = $signed({{2{off_q[63]}}, off_q});

	// clamp of remote capture plus offset
	always_comb begin
		if (cand_q[65] || (cand_q == '0)) begin
			stc_c = item_q.now_us;
		end else if (cand_q[64]) begin
			stc_c = U64_MAX;
		end else begin
			stc_c = cand_q[63:0];
		end
	end

	// local overhead plus remote latency, saturated
	assign v_pos   = !v_q[65] && (v_q != '0);
	assign lat_sum = {1'b0, v_q[31:0]} + {1'b0, item_q.remote_latency_us};
	always_comb begin
		if (!ready_q || !v_pos) begin
			lat_c = item_q.remote_latency_us;
		end else if (v_q[64:32] != '0) begin
			lat_c = U32_MAX;
		end else if (lat_sum[32]) begin
			lat_c = U32_MAX;
		end else begin
			lat_c = lat_sum[31:0];
		end
	end

	// monotonic stamp
	assign base_c  = ready_q ? stc_q : item_q.now_us;
	assign stamp_c = (base_c <= last_q) ? ((last_q == U64_MAX) ? U64_MAX : last_q + 64'd1)
	                                    : base_c;

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (in_data.mode == MODE_FRAME)) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT:   state_d = ST_HI;
			ST_HI:     state_d = ST_LO;
			ST_LO:     state_d = ST_LAUNCH;
			ST_LAUNCH: state_d = ST_SCAN;
			ST_SCAN: begin
				if (tok[RING_DEPTH].go) begin
					state_d = scan_hit ? ST_SUM : ST_OFF;
				end
			end
			ST_SUM:    state_d = ST_DIFF;
			ST_DIFF:   state_d = ST_RAW;
			ST_RAW:    state_d = ST_SDIF;
			ST_SDIF:   state_d = ready_q ? ST_MUL : ST_OFF;
			ST_MUL:    state_d = ST_ACC;
			ST_ACC:    state_d = ST_UPD;
			ST_UPD:    state_d = ST_OFF;
			ST_OFF:    state_d = ST_CAND;
			ST_CAND:   state_d = ST_CLAMP;
			ST_CLAMP:  state_d = ST_FINAL;
			ST_FINAL: begin
				if (load_ok) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// control and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_wait_q  <= MAX_REMOTE_WAIT_RST;
			max_rtt_q   <= MAX_WIRE_RTT_RST;
			wr_pos_q    <= '0;
			prev_seq_q  <= '0;
			await_q     <= 1'b1;
			ready_q     <= 1'b0;
			smooth_q    <= '0;
			last_q      <= '0;
			missed_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx)
					REG_MAX_REMOTE_WAIT: max_wait_q <= cfg_data;
					REG_MAX_WIRE_RTT:    max_rtt_q  <= cfg_data;
					default: ;
				endcase
			end
			if (ring_we) begin
				wr_pos_q <= (wr_pos_q == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_pos_q + PTR_W'(1);
			end
			if (state_q == ST_WAIT) begin
				if (!await_q) begin
					missed_q <= missed_q + {16'b0, gap_c};
				end
				await_q    <= 1'b0;
				prev_seq_q <= item_q.frame_seq;
			end
			// first sample loads the average as it is and restarts the stamp floor
			if ((state_q == ST_SDIF) && !ready_q) begin
				smooth_q <= raw_q;
				ready_q  <= 1'b1;
				last_q   <= '0;
			end
			if (state_q == ST_UPD) begin
				smooth_q <= smooth_q + inc_q;
			end
			if ((state_q == ST_FINAL) && load_ok) begin
				last_q      <= stamp_c;
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// frame datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= in_data;
		end
		if (state_q == ST_WAIT) begin
			gap_q  <= await_q ? 16'd0 : gap_c;
			chk_q  <= (item_q.remote_sync_rx_us != '0) && !wd_c[64];
			wait_q <= wd_c[63:0];
			s2_q   <= {1'b0, item_q.remote_sync_rx_us} + {1'b0, item_q.remote_capture_us};
		end
		if (state_q == ST_HI) begin
			wok_q <= chk_q && (wait_q < {32'b0, max_wait_q});
			hi_q  <= $signed({2'b00, item_q.now_us}) - $signed({2'b00, wait_q});
		end
		if (state_q == ST_LO) begin
			lo_q <= hi_q - $signed({34'b0, max_rtt_q});
		end
		if (state_q == ST_SCAN) begin
			sample_q <= scan_hit;
			best_q   <= tok[RING_DEPTH].best;
		end
		if (state_q == ST_SUM) begin
			s1_q <= {1'b0, best_q} + {1'b0, item_q.now_us};
		end
		if (state_q == ST_DIFF) begin
			diff_q <= $signed({1'b0, s1_q}) - $signed({1'b0, s2_q});
		end
		if (state_q == ST_RAW) begin
			raw_q <= raw_c;
		end
		if (state_q == ST_SDIF) begin
			sdiff_q <= sdiff_c;
		end
		if (state_q == ST_MUL) begin
			plo_q <= plo_c;
			phi_q <= phi_c;
		end
		if (state_q == ST_ACC) begin
			inc_q <= {{2{acc_c[77]}}, acc_c[77:16]};
		end
		if (state_q == ST_OFF) begin
			off_q <= off_c;
		end
		if (state_q == ST_CAND) begin
			cand_q <= $signed({2'b00, item_q.remote_capture_us}) + off_x;
			nt_q   <= $signed({2'b00, item_q.now_us}) - $signed({2'b00, item_q.remote_capture_us});
		end
		if (state_q == ST_CLAMP) begin
			v_q   <= nt_q - off_x;
			stc_q <= stc_c;
		end
		if ((state_q == ST_FINAL) && load_ok) begin
			out_q.stamp_us              <= stamp_c;
			out_q.end_to_end_latency_us <= lat_c;
			out_q.gap_count             <= gap_q;
			out_q.loss_total            <= missed_q;
			out_q.offset_valid          <= ready_q;
			out_q.sample_taken          <= sample_q;
			out_q.offset_q8             <= smooth_q;
		end
	end

`ifndef NO_ASSERTIONS
	// the token leaves the last cell after passing every cell in turn from launch
	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LAUNCH) |-> ##RING_DEPTH tok[RING_DEPTH].go)
		else $error("scan token did not leave the ring on time");

	// once an offset exists it is never lost
	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |=> ready_q)
		else $error("offset ready dropped");

	// first sample clears the stamp floor
	a_first_floor: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ready_q) |-> (last_q == '0))
		else $error("stamp floor not cleared on first sample");

	// every delivered stamp moves forward unless pinned at the top
	a_stamp_mono: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FINAL) && load_ok) |-> ((stamp_c > last_q) || (last_q == U64_MAX)))
		else $error("stamp not monotonic");
`endif

endmodule

FILE: rtl/ftss_ring_cell.sv
// one ring cell: holds a send time and updates the passing search token
module ftss_ring_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [63:0]         wr_data,
	input  ftss_pkg::scan_win_t win,
	input  ftss_pkg::scan_tok_t tok_in,
	output ftss_pkg::scan_tok_t tok_out
);
	import ftss_pkg::*;

	logic [63:0]        entry_q;
	logic signed [65:0] entry_x;
	logic               hit;
	logic               take;
	logic               go_q;
	logic               found_q;
	logic [63:0]        best_q;

	assign entry_x = $signed({2'b00, entry_q});
	// zero means empty; larger send time means smaller wire round trip
	assign hit  = (entry_q != '0) && (entry_x > $signed(win.lo)) && (entry_x < $signed(win.hi));
	assign take = hit && (!tok_in.found || (entry_q > tok_in.best));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			go_q    <= 1'b0;
		end else begin
			go_q <= tok_in.go;
			if (wr_en) begin
				entry_q <= wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		found_q <= tok_in.found | hit;
		best_q  <= take ? entry_q : tok_in.best;
	end

	assign tok_out.go    = go_q;
	assign tok_out.found = found_q;
	assign tok_out.best  = best_q;

endmodule

FILE: tb/tb.sv
// self-checking testbench for the four-timestamp clock sync stamper core
module tb;
	import ftss_pkg::*;

	localparam int SETTLE_CYCLES  = 64;     // comfortably above the frame latency
	localparam int WATCHDOG_LIMIT = 4000;   // cycles with no transfer on either channel
	localparam int MAX_PRINTS     = 100;
	localparam int RING_SLOTS     = RING_DEPTH_DEF;

	// limits of the exact offset sum before it is scaled into q8
	localparam logic signed [71:0] Q8_SUM_TOP    = (72'sd1 <<< 56) - 72'sd1;
	localparam logic signed [71:0] Q8_SUM_BOTTOM = -(72'sd1 <<< 56);
	localparam logic signed [71:0] U64_TOP_W     = {8'd0, {64{1'b1}}};
	localparam logic signed [71:0] U32_TOP_W     = {40'd0, {32{1'b1}}};
	localparam logic signed [63:0] OFFSET_TOP    = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] OFFSET_BOTTOM = {1'b1, 63'd0};
	// 0.1 as q0.16 and the half-lsb rounding term
	localparam logic signed [95:0] EMA_WEIGHT    = 96'sd6554;
	localparam logic signed [95:0] EMA_ROUND     = 96'sd32768;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY
	} stall_style_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// our own copy of the stamper state
	logic [63:0]        sent_t1 [RING_SLOTS];
	int unsigned        sent_pos;
	logic [15:0]        last_seq;
	logic               first_frame_due;
	logic               have_offset;
	logic signed [63:0] offset_avg;
	logic [63:0]        prev_stamp;
	logic [31:0]        frames_missed;
	logic [31:0]        remote_wait_lim;
	logic [31:0]        wire_rtt_lim;

	in_item_t  items_to_send [$];
	out_item_t stamps_due [$];
	int        mismatches = 0;

	// stimulus generator state: local clock, remote skew and sequence number
	logic [63:0] gen_now;
	logic [63:0] gen_skew;
	logic [15:0] gen_seq;

	// sender burst state
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	logic        drain_hold = 1'b0;

	// receiver stall pattern
	stall_style_t stall_style = STALL_NONE;
	int unsigned  stall_phase_left = 0;

	int unsigned quiet_cycles = 0;
	out_item_t   got_stamp;
	out_item_t   want_stamp;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	four_timestamp_clock_sync_stamper_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("mismatch on %s: got %h, want %h", what, got, want);
	endtask

	// works out what one accepted transfer does to the stamper and queues its result
	task automatic track_stamper(input in_item_t it);
		logic [15:0]        gap;
		logic               sample;
		logic               found;
		logic [63:0]        hold_us;
		logic [63:0]        t1;
		logic [63:0]        w;
		logic [63:0]        best_t1;
		logic [63:0]        best_w;
		logic [63:0]        stamp;
		logic signed [71:0] sum;
		logic signed [71:0] diff;
		logic signed [71:0] cand;
		logic signed [71:0] ov;
		logic signed [71:0] lat;
		logic signed [95:0] step;
		logic signed [63:0] raw;
		logic signed [63:0] off;
		out_item_t          res;
		int                 i;

		if (it.mode == MODE_SYNC) begin
			sent_t1[sent_pos] = it.now_us;
			sent_pos = (sent_pos + 1) % RING_SLOTS;
			return;
		end

		// sequence gap, not counted on the very first frame
		gap = '0;
		if (!first_frame_due) begin
			gap = it.frame_seq - (last_seq + 16'd1);
			frames_missed = frames_missed + {16'd0, gap};
		end
		first_frame_due = 1'b0;
		last_seq = it.frame_seq;

		// choose the send time with the smallest plausible wire round trip
		sample = 1'b0;
		found = 1'b0;
		best_t1 = '0;
		best_w = '0;
		if (it.remote_sync_rx_us != '0 && it.remote_capture_us >= it.remote_sync_rx_us
				&& it.remote_capture_us - it.remote_sync_rx_us < {32'd0, remote_wait_lim}) begin
			hold_us = it.remote_capture_us - it.remote_sync_rx_us;
			for (i = 0; i < RING_SLOTS; i++) begin
				t1 = sent_t1[i];
				if (t1 != '0 && it.now_us >= t1 && it.now_us - t1 > hold_us) begin
					w = it.now_us - t1 - hold_us;
					if (w < {32'd0, wire_rtt_lim} && (!found || w < best_w)) begin
						found = 1'b1;
						best_w = w;
						best_t1 = t1;
					end
				end
			end
			if (found) begin
				// ((t1 + t4) - (t2 + t3)) / 2 in q8, i.e. the exact sum times 128
				sum = $signed({8'd0, best_t1}) + $signed({8'd0, it.now_us})
					- $signed({8'd0, it.remote_sync_rx_us})
					- $signed({8'd0, it.remote_capture_us});
				if (sum > Q8_SUM_TOP) begin
					raw = OFFSET_TOP;
				end else if (sum < Q8_SUM_BOTTOM) begin
					raw = OFFSET_BOTTOM;
				end else begin
					sum = sum <<< 7;
					raw = sum[63:0];
				end
				sample = 1'b1;
				if (!have_offset) begin
					offset_avg = raw;
					have_offset = 1'b1;
					prev_stamp = '0;
				end else begin
					diff = 72'(raw) - 72'(offset_avg);
					if (diff > 72'(OFFSET_TOP))
						diff = 72'(OFFSET_TOP);
					else if (diff < 72'(OFFSET_BOTTOM))
						diff = 72'(OFFSET_BOTTOM);
					// floor((diff * 0.1q16 + half) / 2^16)
					step = 96'(diff) * EMA_WEIGHT + EMA_ROUND;
					step = step >>> 16;
					offset_avg = offset_avg + step[63:0];
				end
			end
		end

		if (have_offset) begin
			off = offset_avg / 64'sd256;
			cand = $signed({8'd0, it.remote_capture_us}) + 72'(off);
			if (cand <= 0)
				stamp = it.now_us;
			else if (cand > U64_TOP_W)
				stamp = '1;
			else
				stamp = cand[63:0];
			ov = $signed({8'd0, it.now_us}) - $signed({8'd0, it.remote_capture_us}) - 72'(off);
			if (ov < 0)
				ov = '0;
			else if (ov > U64_TOP_W)
				ov = U64_TOP_W;
			lat = ov + $signed({40'd0, it.remote_latency_us});
			if (lat > U32_TOP_W)
				lat = U32_TOP_W;
		end else begin
			stamp = it.now_us;
			lat = $signed({40'd0, it.remote_latency_us});
		end

		// keep stamps strictly rising, holding at the top of the range
		if (stamp <= prev_stamp)
			stamp = (prev_stamp == '1) ? prev_stamp : prev_stamp + 64'd1;
		prev_stamp = stamp;

		res.stamp_us = stamp;
		res.end_to_end_latency_us = lat[31:0];
		res.gap_count = gap;
		res.loss_total = frames_missed;
		res.offset_valid = have_offset;
		res.sample_taken = sample;
		res.offset_q8 = offset_avg;
		stamps_due.push_back(res);
	endtask

	function automatic void queue_item(input logic mode, input logic [63:0] now,
			input logic [63:0] t2, input logic [63:0] t3, input logic [15:0] seq,
			input logic [31:0] rlat);
		in_item_t it;
		it.mode = mode;
		it.now_us = now;
		it.remote_sync_rx_us = t2;
		it.remote_capture_us = t3;
		it.frame_seq = seq;
		it.remote_latency_us = rlat;
		items_to_send.push_back(it);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until everything sent has been accepted and answered, then let the block go quiet
	task automatic drain();
		while (items_to_send.size() != 0 || in_valid || stamps_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// one register setting, then exchanges: a few sync sends followed by frames that answer them
	task automatic run_phase(input logic [31:0] wait_lim, input logic [31:0] rtt_lim,
			input int unsigned hold_max, input int unsigned wire_max, input int n_items);
		int          made;
		int          n_sync;
		int          n_frames;
		int          k;
		logic [63:0] t1_list [3];
		logic [63:0] t1;
		logic [63:0] t2;
		logic [63:0] t3;
		logic [63:0] t4;
		int unsigned d_out;
		int unsigned d_back;
		int unsigned hold;

		write_reg(REG_MAX_REMOTE_WAIT, wait_lim);
		write_reg(REG_MAX_WIRE_RTT, rtt_lim);
		// remote clock runs some way off ours, within about 2^39 us either side
		gen_skew = {32'd0, $urandom} << 8;
		gen_skew = gen_skew - (64'd1 << 39);
		made = 0;
		while (made < n_items) begin
			n_sync = $urandom_range(1, 3);
			for (k = 0; k < n_sync; k++) begin
				gen_now = gen_now + 64'($urandom_range(1, 4000));
				t1_list[k] = gen_now;
				queue_item(MODE_SYNC, gen_now, {$urandom, $urandom}, {$urandom, $urandom},
					16'($urandom), $urandom);
			end
			n_frames = $urandom_range(1, 3);
			for (k = 0; k < n_frames; k++) begin
				t1 = t1_list[$urandom_range(0, n_sync - 1)];
				d_out = $urandom_range(0, wire_max);
				d_back = $urandom_range(0, wire_max);
				hold = $urandom_range(0, hold_max);
				t2 = t1 + gen_skew + 64'(d_out);
				t3 = t2 + 64'(hold);
				t4 = t1 + 64'(d_out) + 64'(hold) + 64'(d_back);
				if (t4 > gen_now)
					gen_now = t4;
				// now and then a frame without sync info or with capture before reception
				case ($urandom_range(0, 11))
					0: t2 = '0;
					1: t3 = t2 - 64'(hold) - 64'd1;
					default: ;
				endcase
				// mostly in order, sometimes a jump or a repeat
				case ($urandom_range(0, 15))
					0: gen_seq = 16'($urandom);
					1: ;
					default: gen_seq = gen_seq + 16'd1;
				endcase
				queue_item(MODE_FRAME, t4, t2, t3, gen_seq,
					($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20000));
			end
			made = made + n_sync + n_frames;
			if ($urandom_range(0, 7) == 0) begin
				t2 = gen_now + gen_skew - 64'($urandom_range(0, 1 << 20));
				queue_item(1'($urandom_range(0, 1)), gen_now + 64'($urandom_range(0, 1 << 20)),
					t2, t2 + 64'($urandom_range(0, 1 << 18)), 16'($urandom), $urandom);
				made++;
			end
		end
		drain();
	endtask

	// sender: bursts of transfers with random gaps, occasionally holding off until drained
	always @(posedge clk) begin : sender
		logic next_valid;
		if (arst_n) begin
			if (in_valid && !in_stall)
				track_stamper(in_data);
			if (!(in_valid && in_stall)) begin
				next_valid = 1'b0;
				if (burst_left == 0) begin
					if (gap_left != 0) begin
						gap_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
						drain_hold = ($urandom_range(0, 11) == 0);
					end
				end
				if (drain_hold && stamps_due.size() == 0)
					drain_hold = 1'b0;
				if (burst_left != 0 && !drain_hold && items_to_send.size() != 0) begin
					in_data <= items_to_send.pop_front();
					next_valid = 1'b1;
					burst_left--;
				end
				in_valid <= next_valid;
			end
		end
	end

	// receiver: switches between no stalls, light stalls and heavy stalls
	always @(posedge clk) begin
		if (stall_phase_left == 0) begin
			stall_style = stall_style_t'($urandom_range(0, 2));
			stall_phase_left = $urandom_range(50, 300);
		end else begin
			stall_phase_left--;
		end
		case (stall_style)
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 4) != 0);
			default:     out_stall <= 1'b0;
		endcase
	end

	// register writes take effect at the edge that sees the write enable
	always @(posedge clk) begin
		if (arst_n && cfg_we) begin
			case (cfg_idx)
				REG_MAX_REMOTE_WAIT: remote_wait_lim = cfg_data;
				REG_MAX_WIRE_RTT:    wire_rtt_lim = cfg_data;
				default: ;
			endcase
		end
	end

	// result checker: each output transfer against the oldest predicted stamp
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_stamp = out_data;
			if (stamps_due.size() == 0) begin
				report_mismatch("result with nothing due", got_stamp.stamp_us, '0);
			end else begin
				want_stamp = stamps_due.pop_front();
				if (got_stamp.stamp_us !== want_stamp.stamp_us)
					report_mismatch("stamp_us", got_stamp.stamp_us, want_stamp.stamp_us);
				if (got_stamp.end_to_end_latency_us !== want_stamp.end_to_end_latency_us)
					report_mismatch("end_to_end_latency_us",
						64'(got_stamp.end_to_end_latency_us),
						64'(want_stamp.end_to_end_latency_us));
				if (got_stamp.gap_count !== want_stamp.gap_count)
					report_mismatch("gap_count", 64'(got_stamp.gap_count),
						64'(want_stamp.gap_count));
				if (got_stamp.loss_total !== want_stamp.loss_total)
					report_mismatch("loss_total", 64'(got_stamp.loss_total),
						64'(want_stamp.loss_total));
				if (got_stamp.offset_valid !== want_stamp.offset_valid)
					report_mismatch("offset_valid", 64'(got_stamp.offset_valid),
						64'(want_stamp.offset_valid));
				if (got_stamp.sample_taken !== want_stamp.sample_taken)
					report_mismatch("sample_taken", 64'(got_stamp.sample_taken),
						64'(want_stamp.sample_taken));
				if (got_stamp.offset_q8 !== want_stamp.offset_q8)
					report_mismatch("offset_q8", got_stamp.offset_q8, want_stamp.offset_q8);
			end
		end
	end

	// watchdog: too long without any transfer ends the run
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < RING_SLOTS; i++)
			sent_t1[i] = '0;
		sent_pos = 0;
		last_seq = '0;
		first_frame_due = 1'b1;
		have_offset = 1'b0;
		offset_avg = '0;
		prev_stamp = '0;
		frames_missed = '0;
		remote_wait_lim = 32'd100000;
		wire_rtt_lim = 32'd10000;
		gen_now = 64'd1 << 41;
		gen_skew = '0;
		gen_seq = 16'd1;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at the reset register values (wait 100000, round trip 10000)
		// first frame, before any sync: no gap counted, stamp is the local time
		queue_item(MODE_FRAME, 64'd1000, 64'd0, 64'd0, 16'd5, 32'd7);
		// capture before reception
		queue_item(MODE_FRAME, 64'd1100, 64'd500, 64'd400, 16'd6, 32'd0);
		// a zero send time is an empty slot; two equal send times make a tie
		queue_item(MODE_SYNC, 64'd0, 64'd0, 64'd0, 16'd0, 32'd0);
		queue_item(MODE_SYNC, 64'd2000, '1, '1, '1, '1);
		queue_item(MODE_SYNC, 64'd2000, 64'd0, 64'd0, 16'd0, 32'd0);
		queue_item(MODE_SYNC, 64'd9000, 64'd0, 64'd0, 16'd0, 32'd0);
		// first sample, gap of two, lower slot wins the tie, later send time skipped
		queue_item(MODE_FRAME, 64'd2600, 64'd50000, 64'd50100, 16'd9, 32'd30);
		// hold time one below its limit, round trip one below its limit
		queue_item(MODE_FRAME, 64'd118998, 64'd50000, 64'd149999, 16'd10, 32'd40);
		// hold time equal to its limit
		queue_item(MODE_FRAME, 64'd130000, 64'd60000, 64'd160000, 16'd11, 32'd0);
		queue_item(MODE_SYNC, 64'd200000, 64'd0, 64'd0, 16'd0, 32'd0);
		// round trip equal to its limit
		queue_item(MODE_FRAME, 64'd210100, 64'd300000, 64'd300100, 16'd12, 32'd0);
		// zero round trip
		queue_item(MODE_FRAME, 64'd200100, 64'd300000, 64'd300100, 16'd13, 32'd0);
		queue_item(MODE_SYNC, 64'd400000, 64'd0, 64'd0, 16'd0, 32'd0);
		// sequence wraps through 65535 to 0, then a repeated number
		queue_item(MODE_FRAME, 64'd400700, 64'd500000, 64'd500200, 16'hFFFF, 32'd100);
		queue_item(MODE_FRAME, 64'd401000, 64'd500000, 64'd500200, 16'd0, 32'd200);
		queue_item(MODE_FRAME, 64'd401200, 64'd500000, 64'd500200, 16'd0, 32'hFFFF_FFFF);
		// negative offset drives the stamp below zero, and it falls behind the last one
		queue_item(MODE_FRAME, 64'd5, 64'd0, 64'd10, 16'd1, 32'd0);
		// ring wraps over the oldest entries
		queue_item(MODE_SYNC, 64'd402000, 64'd0, 64'd0, 16'd0, 32'd0);
		queue_item(MODE_SYNC, 64'd402100, 64'd0, 64'd0, 16'd0, 32'd0);
		queue_item(MODE_SYNC, 64'd402200, 64'd0, 64'd0, 16'd0, 32'd0);
		queue_item(MODE_SYNC, 64'd402300, 64'd0, 64'd0, 16'd0, 32'd0);
		queue_item(MODE_FRAME, 64'd402500, 64'd502000, 64'd502100, 16'd2, 32'd1);
		drain();

		// random exchanges over several register settings, extremes included
		run_phase(32'd100000, 32'd10000, 3000, 2000, 300);
		run_phase(32'd1, 32'd20000, 1, 8000, 250);
		run_phase(32'd500, 32'd1, 800, 1000, 200);
		run_phase(32'd40000, 32'd3000, 60000, 2000, 300);
		run_phase('1, '1, 200000, 100000, 250);

		// full-range noise; it pushes the stamp up fast, so it comes last
		for (int n = 0; n < 150; n++) begin
			gen_now = {$urandom, $urandom};
			queue_item(1'($urandom_range(0, 1)), {$urandom, $urandom}, gen_now,
				($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : gen_now + 64'($urandom),
				16'($urandom), $urandom);
		end
		// offset sum saturating high, the stamp saturating, then the sum saturating low
		queue_item(MODE_SYNC, 64'h8000_0000_0000_0000, 64'd0, 64'd0, 16'd0, 32'd0);
		for (int n = 0; n < 4; n++)
			queue_item(MODE_FRAME, 64'h8000_0000_0000_0064, 64'd1, 64'd2, gen_seq + 16'(n),
				32'd0);
		queue_item(MODE_FRAME, '1, 64'hFFFF_FFFF_FFFF_FFFA, '1, 16'hFFFF, 32'hFFFF_FFFF);
		queue_item(MODE_SYNC, 64'd10, 64'd0, 64'd0, 16'd0, 32'd0);
		queue_item(MODE_FRAME, 64'd200, 64'hFFFF_FFFF_FFFF_FF9C, 64'hFFFF_FFFF_FFFF_FFCE,
			16'd0, 32'd0);
		queue_item(MODE_FRAME, 64'd300, 64'hFFFF_FFFF_FFFF_FF9C, 64'hFFFF_FFFF_FFFF_FFCE,
			16'd1, 32'hFFFF_FFFF);
		queue_item(MODE_SYNC, '1, '1, '1, '1, '1);
		queue_item(MODE_FRAME, 64'd0, 64'd0, 64'd0, 16'd2, 32'd0);
		drain();

		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/ftss_pkg.sv
rtl/ftss_ring_cell.sv
rtl/four_timestamp_clock_sync_stamper_core.sv
tb/tb.sv
